### rtl/irpfd_pkg.sv
// ============================================================================
// irpfd_pkg
// Shared types and constants for the infrared pulse frame decoder.
// ============================================================================
package irpfd_pkg;

    localparam int FRAME_BITS_DEF = 32;
    localparam int WIDTH_W        = 16;
    localparam int WORD_W         = 32;
    localparam int BYTE_W         = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int OUT_TDATA_W    = 48;

    localparam logic [CFG_IDX_W-1:0] REG_BREAK_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_CENTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_CENTER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 2'd3;

    typedef enum logic [1:0] {
        BIT_NONE = 2'd0,
        BIT_ZERO = 2'd1,
        BIT_ONE  = 2'd2
    } bit_kind_t;

    typedef struct packed {
        logic      lead;
        bit_kind_t kind;
    } pulse_class_t;

    localparam int CLASS_W = $bits(pulse_class_t);

endpackage

### rtl/irpfd_classify.sv
// ============================================================================
// irpfd_classify
// Front end: holds the window registers and sorts each pulse into the
// leader window and the zero or one bit windows.
// ============================================================================
module irpfd_classify
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [irpfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [irpfd_pkg::WIDTH_W-1:0]       cfg_data,
    input  logic [irpfd_pkg::WIDTH_W-1:0]       pulse_width,
    output irpfd_pkg::pulse_class_t             pulse_class
);

    localparam int EXT_W = irpfd_pkg::WIDTH_W + 2;

    logic [irpfd_pkg::WIDTH_W-1:0] break_center_reg;
    logic [irpfd_pkg::WIDTH_W-1:0] short_center_reg;
    logic [irpfd_pkg::WIDTH_W-1:0] long_center_reg;
    logic [irpfd_pkg::WIDTH_W-1:0] tolerance_reg;

    logic in_break;
    logic in_short;
    logic in_long;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break_center_reg <= 16'd562;
            short_center_reg <= 16'd67;
            long_center_reg  <= 16'd187;
            tolerance_reg    <= 16'd50;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                irpfd_pkg::REG_BREAK_CENTER: break_center_reg <= cfg_data;
                irpfd_pkg::REG_SHORT_CENTER: short_center_reg <= cfg_data;
                irpfd_pkg::REG_LONG_CENTER:  long_center_reg  <= cfg_data;
                irpfd_pkg::REG_TOLERANCE:    tolerance_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic in_window(
        input logic [irpfd_pkg::WIDTH_W-1:0] w,
        input logic [irpfd_pkg::WIDTH_W-1:0] center,
        input logic [irpfd_pkg::WIDTH_W-1:0] tol
    );
        logic signed [EXT_W-1:0] v;
        logic signed [EXT_W-1:0] lo;
        logic signed [EXT_W-1:0] hi;
        v  = $signed({2'b00, w});
        lo = $signed({2'b00, center}) - $signed({2'b00, tol});
        hi = $signed({2'b00, center}) + $signed({2'b00, tol});
        return (v > lo) && (v < hi);
    endfunction

    always_comb
    begin
        in_break = in_window(pulse_width, break_center_reg, tolerance_reg);
        in_short = in_window(pulse_width, short_center_reg, tolerance_reg);
        in_long  = in_window(pulse_width, long_center_reg, tolerance_reg);

        pulse_class.lead = in_break;
        if (in_short)
        begin
            pulse_class.kind = irpfd_pkg::BIT_ZERO;
        end
        else if (in_long)
        begin
            pulse_class.kind = irpfd_pkg::BIT_ONE;
        end
        else
        begin
            pulse_class.kind = irpfd_pkg::BIT_NONE;
        end
    end

endmodule

### rtl/irpfd_queue.sv
// ============================================================================
// irpfd_queue
// Two-entry queue of classified pulses between the front and back ends.
// ============================================================================
module irpfd_queue
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  irpfd_pkg::pulse_class_t  push_data,
    output logic                     full,
    input  logic                     pop,
    output logic                     valid,
    output irpfd_pkg::pulse_class_t  pop_data
);

    irpfd_pkg::pulse_class_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/irpfd_assemble.sv
// ============================================================================
// irpfd_assemble
// Back end: tracks the frame, shifts in bits and holds the finished frame in
// an output register until the downstream side takes it.
// ============================================================================
module irpfd_assemble
#(
    parameter int FRAME_BITS = irpfd_pkg::FRAME_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    input  irpfd_pkg::pulse_class_t               q_data,
    output logic                                  q_pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [irpfd_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int CNT_W = $clog2(FRAME_BITS + 2);
    localparam logic [CNT_W-1:0] END_COUNT = CNT_W'(FRAME_BITS + 1);
    localparam int PAD_W = irpfd_pkg::OUT_TDATA_W - irpfd_pkg::WORD_W
                           - irpfd_pkg::BYTE_W - 1;

    logic [CNT_W-1:0]               bit_count_reg;
    logic [CNT_W-1:0]               bit_count_next;
    logic [irpfd_pkg::WORD_W-1:0]   shift_word_reg;
    logic [irpfd_pkg::WORD_W-1:0]   shift_word_next;
    logic [irpfd_pkg::WORD_W-1:0]   word_upd;
    logic [CNT_W-1:0]               count_upd;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [irpfd_pkg::WORD_W-1:0]   out_word_reg;
    logic [irpfd_pkg::WORD_W-1:0]   out_word_next;
    logic                           done;

    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        count_upd = bit_count_reg;
        word_upd  = shift_word_reg;
        if (bit_count_reg == '0)
        begin
            if (q_data.lead)
            begin
                count_upd = CNT_W'(1);
            end
        end
        else
        begin
            unique case (q_data.kind)
                irpfd_pkg::BIT_ZERO:
                begin
                    count_upd = bit_count_reg + CNT_W'(1);
                    word_upd  = {shift_word_reg[irpfd_pkg::WORD_W-2:0], 1'b0};
                end
                irpfd_pkg::BIT_ONE:
                begin
                    count_upd = bit_count_reg + CNT_W'(1);
                    word_upd  = {shift_word_reg[irpfd_pkg::WORD_W-2:0], 1'b1};
                end
                default: ;
            endcase
        end

        done            = (count_upd == END_COUNT);
        bit_count_next  = bit_count_reg;
        shift_word_next = shift_word_reg;
        out_word_next   = out_word_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        if (q_pop)
        begin
            if (done)
            begin
                bit_count_next  = '0;
                shift_word_next = word_upd + irpfd_pkg::WORD_W'(1);
                out_word_next   = word_upd;
                out_valid_next  = 1'b1;
            end
            else
            begin
                bit_count_next  = count_upd;
                shift_word_next = word_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= '0;
            shift_word_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bit_count_reg  <= bit_count_next;
            shift_word_reg <= shift_word_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        {PAD_W{1'b0}},
        (out_word_reg[15:8] == ~out_word_reg[7:0]),
        out_word_reg[15:8],
        out_word_reg
    };

endmodule

### rtl/ir_pulse_frame_decoder.sv
// ============================================================================
// ir_pulse_frame_decoder
// Pulse-width frame decoder for a pulse-distance infrared remote protocol.
// ============================================================================
// Usage:
// The slave stream carries one measured pulse width per beat. A width inside
// the leader window starts a frame; inside a frame, short and long widths
// shift in a zero or a one, and all other widths are ignored.
// Once FRAME_BITS bits are in, one beat goes out on the master stream with
// the frame word, its command byte and a check flag that is set when the
// command byte equals the inverse of the low byte.
// The window registers are written by the user through the cfg port only
// while the block is idle, which the block does not enforce: 0 leader center,
// 1 short center, 2 long center, 3 tolerance. A pulse beat is accepted in
// every cycle while the two-entry queue between the classifier and the frame
// assembler has room. The frame beat comes from the output register. When
// the receiver stalls, the output register holds its beat, the assembler
// stops, and the queue fills; s_tready falls once two pulses are queued.
// Reset clears the frame state and the queue and loads the default windows.
// ============================================================================
module ir_pulse_frame_decoder
#(
    parameter int FRAME_BITS = irpfd_pkg::FRAME_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [irpfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [irpfd_pkg::WIDTH_W-1:0]         cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata: pulse_width[15:0]
    input  logic [irpfd_pkg::WIDTH_W-1:0]         s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: frame_word[31:0], command_byte[39:32], frame_valid[40], zero
    output logic [irpfd_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    irpfd_pkg::pulse_class_t pulse_class;
    irpfd_pkg::pulse_class_t q_data;
    logic                    q_full;
    logic                    q_valid;
    logic                    q_pop;
    logic                    q_push;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    irpfd_classify u_classify
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pulse_width (s_tdata),
        .pulse_class (pulse_class)
    );

    irpfd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (pulse_class),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    irpfd_assemble #(
        .FRAME_BITS (FRAME_BITS)
    ) u_assemble
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_check_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[40] == (m_tdata[15:8] == ~m_tdata[7:0])))
        else $error("frame check flag does not match frame word");

    a_cmd_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39:32] == m_tdata[15:8]))
        else $error("command byte does not match frame word");

    a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !q_pop)
        else $error("assembler advanced while output stalled");
`endif

endmodule
